/* src/pfbrf_pkg.sv */
`default_nettype none

package pfbrf_pkg;

    // Default geometry of the page store
    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_PAGES_DEF   = 8;

    // Register reset values
    localparam logic [7:0] BUF_WIDTH_RST  = 8'd128;
    localparam logic [6:0] BUF_HEIGHT_RST = 7'd64;

    // Register indexes on the configuration port
    localparam logic REG_BUF_WIDTH  = 1'b0;
    localparam logic REG_BUF_HEIGHT = 1'b1;

    // Item kinds carried in tuser
    localparam logic MODE_FILL = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Width of the page-times-stride product (31 * 255 fits)
    localparam int BASE_W = 13;

    localparam logic [7:0] BYTE_ONES = 8'hFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_FILL,
        ST_FLUSH,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* src/pfbrf_ram.sv */
`default_nettype none

module pfbrf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* src/page_framebuffer_rect_fill_top.sv */
`default_nettype none

// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: pos_x, pos_y, rect_width,
//                                               rect_height, colour; tuser: mode
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: read_byte; tuser: in_range
// cfg       in   i_cfg_we (no back-pressure)    i_cfg_index, i_cfg_data
//
// After reset a clearing pass zeroes the page store, one byte per cycle, over all
// MAX_COLUMNS * MAX_PAGES bytes (1024 by default); no item is taken meanwhile.
// A fill goes through SETUP, FILL with one read-modify-write per covered byte,
// FLUSH and DONE; a fill that clips to nothing goes from SETUP straight to DONE.
// A finished result waits in the output register while the next item is accepted;
// a stalled output holds the block in its last step.

module page_framebuffer_rect_fill_top #(
    parameter int MAX_COLUMNS = pfbrf_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_PAGES   = pfbrf_pkg::MAX_PAGES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // pos_x[7:0], pos_y[15:8], rect_width[23:16],
                                            // rect_height[31:24], colour[32], zero[39:33]
    input  wire logic [0:0]  s_axis_tuser,  // mode[0]
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // read_byte[7:0]
    output logic [0:0]       m_axis_tuser,  // in_range[0]
    // configuration writes
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int DEPTH  = MAX_COLUMNS * MAX_PAGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int HLIM   = MAX_PAGES * 8;
    localparam int BW     = pfbrf_pkg::BASE_W;

    pfbrf_pkg::t_state r_state, n_state;

    // configuration
    logic [7:0] r_buf_width;
    logic [6:0] r_buf_height;

    // accepted item
    logic       r_mode;
    logic [7:0] r_x, r_y, r_w, r_h;
    logic       r_colour;

    // walk over the clipped rectangle
    logic [7:0]    r_col, n_col;
    logic [4:0]    r_pg, n_pg;
    logic [BW-1:0] r_base, n_base;
    logic [7:0]    r_x_last, r_y_last;
    logic          r_hit;

    // pending write-back of the previous cycle's read
    logic              r_wp;
    logic [ADDR_W-1:0] r_wa;
    logic [7:0]        r_wm;

    logic [ADDR_W-1:0] r_clr_addr;

    // output register
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_hit;
    logic       out_load;

    // clipping
    logic [7:0]    uw, xe, xe_c, ye, ye_c;
    logic [6:0]    uh;
    logic          empty, hit;
    logic [BW-1:0] prod, addr_full;
    logic [2:0]    lo, hi;
    logic [7:0]    mask;
    logic          col_end, pg_end;

    // memory ports
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata, mem_rdata;

    logic accept;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == pfbrf_pkg::ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_hit;

    // Clip against the usable area; end sums wrap at eight bits.
    always_comb begin
        uw   = (r_buf_width > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : r_buf_width;
        uh   = ({2'b00, r_buf_height} > 9'(HLIM)) ? 7'(HLIM) : r_buf_height;
        xe   = r_x + r_w;
        ye   = r_y + r_h;
        xe_c = (xe > uw) ? uw : xe;
        ye_c = (ye > {1'b0, uh}) ? {1'b0, uh} : ye;
        empty = (ye_c <= r_y) || (xe_c <= r_x);
        hit   = (r_x < uw) && (r_y < {1'b0, uh});
        prod  = BW'(r_y[7:3]) * BW'(uw);
    end

    // Bits of the current page that the rectangle covers; top pixel is the MSB.
    always_comb begin
        lo        = (r_pg == r_y[7:3]) ? r_y[2:0] : 3'd0;
        hi        = (r_pg == r_y_last[7:3]) ? r_y_last[2:0] : 3'd7;
        mask      = (pfbrf_pkg::BYTE_ONES >> lo) & (pfbrf_pkg::BYTE_ONES << (3'd7 - hi));
        addr_full = r_base + BW'(r_col);
        col_end   = (r_col == r_x_last);
        pg_end    = (r_pg == r_y_last[7:3]);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfbrf_pkg::ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) n_state = pfbrf_pkg::ST_IDLE;
            end
            pfbrf_pkg::ST_IDLE: begin
                if (accept) n_state = pfbrf_pkg::ST_SETUP;
            end
            pfbrf_pkg::ST_SETUP: begin
                if (r_mode == pfbrf_pkg::MODE_READ) n_state = pfbrf_pkg::ST_READ;
                else if (empty)                     n_state = pfbrf_pkg::ST_DONE;
                else                                n_state = pfbrf_pkg::ST_FILL;
            end
            pfbrf_pkg::ST_FILL: begin
                if (col_end && pg_end) n_state = pfbrf_pkg::ST_FLUSH;
            end
            pfbrf_pkg::ST_FLUSH: n_state = pfbrf_pkg::ST_DONE;
            pfbrf_pkg::ST_READ:  n_state = pfbrf_pkg::ST_DONE;
            pfbrf_pkg::ST_DONE: begin
                if (out_load) n_state = pfbrf_pkg::ST_IDLE;
            end
            default: n_state = pfbrf_pkg::ST_CLEAR;
        endcase
    end

    // memory control and walk counters
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = addr_full[ADDR_W-1:0];
        mem_we    = r_wp;
        mem_waddr = r_wa;
        mem_wdata = r_colour ? (mem_rdata | r_wm) : (mem_rdata & ~r_wm);
        n_col     = r_col;
        n_pg      = r_pg;
        n_base    = r_base;
        out_load  = 1'b0;
        unique case (r_state)
            pfbrf_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            pfbrf_pkg::ST_SETUP: begin
                n_col  = r_x;
                n_pg   = r_y[7:3];
                n_base = prod;
            end
            pfbrf_pkg::ST_FILL: begin
                mem_re = 1'b1;
                if (col_end) begin
                    n_col = r_x;
                    if (!pg_end) begin
                        n_pg   = r_pg + 5'd1;
                        n_base = r_base + BW'(uw);
                    end
                end else begin
                    n_col = r_col + 8'd1;
                end
            end
            pfbrf_pkg::ST_READ: begin
                mem_re = r_hit;
            end
            pfbrf_pkg::ST_DONE: begin
                out_load = !r_out_valid || m_axis_tready;
            end
            pfbrf_pkg::ST_IDLE, pfbrf_pkg::ST_FLUSH: ;
            default: ;
        endcase
        n_out_valid = out_load || (r_out_valid && !m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= pfbrf_pkg::ST_CLEAR;
            r_buf_width  <= pfbrf_pkg::BUF_WIDTH_RST;
            r_buf_height <= pfbrf_pkg::BUF_HEIGHT_RST;
            r_clr_addr   <= '0;
            r_wp         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= (r_state == pfbrf_pkg::ST_FILL);
            r_out_valid <= n_out_valid;
            if (r_state == pfbrf_pkg::ST_CLEAR) r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pfbrf_pkg::REG_BUF_WIDTH:  r_buf_width  <= i_cfg_data;
                    pfbrf_pkg::REG_BUF_HEIGHT: r_buf_height <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= s_axis_tuser[0];
            r_x      <= s_axis_tdata[7:0];
            r_y      <= s_axis_tdata[15:8];
            r_w      <= s_axis_tdata[23:16];
            r_h      <= s_axis_tdata[31:24];
            r_colour <= s_axis_tdata[32];
        end
        if (r_state == pfbrf_pkg::ST_SETUP) begin
            r_x_last <= xe_c - 8'd1;
            r_y_last <= ye_c - 8'd1;
            r_hit    <= hit;
        end
        r_col  <= n_col;
        r_pg   <= n_pg;
        r_base <= n_base;
        // hold the address and mask of this cycle's read for the write-back
        r_wa   <= addr_full[ADDR_W-1:0];
        r_wm   <= mask;
        if (out_load) begin
            r_out_hit  <= (r_mode == pfbrf_pkg::MODE_READ) && r_hit;
            r_out_byte <= ((r_mode == pfbrf_pkg::MODE_READ) && r_hit) ? mem_rdata : 8'd0;
        end
    end

    pfbrf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_page_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re   (mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

endmodule

`default_nettype wire
